FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the sequencer RTL module of the spoke expander.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define RSE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define RSE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hw/rtl/rse_pkg.sv
// Types, constants and codes of the radar spoke run-length expander.
package rse_pkg;

    // Field widths
    localparam int CNT_W  = 11;             // sample counter and limit
    localparam int ROOM_W = CNT_W - 1;      // room counted in pairs
    localparam int PAIR_W = 3;              // pair count per result
    localparam int BYTE_W = 8;

    // Constants of the coding
    localparam logic [BYTE_W-1:0] ESC_BYTE = 8'h5C;
    localparam logic [BYTE_W-1:0] NIB_LO   = 8'h0F;
    localparam logic [BYTE_W-1:0] NIB_HI   = 8'hF0;

    localparam logic [CNT_W-1:0]  SPOKE_SAMPLES_RESET = 11'd512;
    localparam logic [CNT_W-1:0]  MAX_SPOKE_SAMPLES   = 11'd1024;
    localparam logic [PAIR_W-1:0] PAIRS_PER_RESULT    = 3'd4;
    localparam int                OUT_PAIRS           = 4;

    // Escape decoder phase
    typedef enum logic [1:0] {
        PH_NORMAL = 2'd0,
        PH_COUNT  = 2'd1,
        PH_VALUE  = 2'd2
    } esc_phase_t;

    // Sequencer state
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } seq_state_t;

    // Request to the admit unit
    typedef struct packed {
        logic [PAIR_W-1:0] want;
        logic [CNT_W-1:0]  emitted;
    } adm_req_t;

    // Answer of the admit unit
    typedef struct packed {
        logic [PAIR_W-1:0] got;
        logic              dropped;
        logic [CNT_W-1:0]  emitted_next;
    } adm_rsp_t;

    // One result item
    typedef struct packed {
        logic [2*OUT_PAIRS-1:0][BYTE_W-1:0] sample;
        logic [PAIR_W-1:0]                  pair_count;
        logic                               run_last;
        logic                               truncated;
    } result_t;

endpackage

FILE: hw/rtl/rse_if.sv
// Valid/ready channel interfaces for the spoke bytes and the sample results.
interface rse_in_if
    import rse_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              in_tail;
    logic              spoke_start;

    modport source (output valid, data_byte, in_tail, spoke_start, input ready);
    modport sink   (input valid, data_byte, in_tail, spoke_start, output ready);
endinterface

interface rse_out_if
    import rse_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] sample_0;
    logic [BYTE_W-1:0] sample_1;
    logic [BYTE_W-1:0] sample_2;
    logic [BYTE_W-1:0] sample_3;
    logic [BYTE_W-1:0] sample_4;
    logic [BYTE_W-1:0] sample_5;
    logic [BYTE_W-1:0] sample_6;
    logic [BYTE_W-1:0] sample_7;
    logic [PAIR_W-1:0] pair_count;
    logic              run_last;
    logic              truncated;

    modport source (output valid, sample_0, sample_1, sample_2, sample_3, sample_4,
                    sample_5, sample_6, sample_7, pair_count, run_last, truncated,
                    input ready);
    modport sink   (input valid, sample_0, sample_1, sample_2, sample_3, sample_4,
                    sample_5, sample_6, sample_7, pair_count, run_last, truncated,
                    output ready);
endinterface

FILE: hw/rtl/radar_spoke_rle_expander_core.sv
// Top level of the radar spoke run-length expander.
//
// in_ch carries spoke payload bytes (data_byte, in_tail, spoke_start);
// out_ch carries results of up to four sample pairs with pair_count,
// run_last and truncated. Both use valid/ready; an item moves when both
// are high at a rising clock edge.
// cfg_we/cfg_wdata write spoke_samples, the per-spoke sample limit
// (clamped to 1024, rounded down to whole pairs); write only when idle.
// A result is in the output register in the cycle after its byte is
// accepted. Ordinary and tail bytes run at one byte per cycle unless
// stalled. An escape value byte holds off input while the run sequencer
// emits ceil(count/4) results, one per cycle unless stalled, all through
// one admit unit; escape and count bytes give no result.
// Reset clears the escape phase, the sample count and the output valid,
// and sets spoke_samples to 512. When the receiver stalls, the result
// register holds and no new byte or run step is taken until it drains.
module radar_spoke_rle_expander_core
    import rse_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata,
    rse_in_if.sink           in_ch,
    rse_out_if.source        out_ch
);

    logic [CNT_W-1:0] spoke_samples_reg, spoke_samples_next;
    adm_req_t         adm_req;
    adm_rsp_t         adm_rsp;
    result_t          result;

    // Configuration register
    assign spoke_samples_next = cfg_we ? cfg_wdata : spoke_samples_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spoke_samples_reg <= SPOKE_SAMPLES_RESET;
        end
        else
        begin
            spoke_samples_reg <= spoke_samples_next;
        end
    end

    // Shared admit unit
    rse_admit u_admit (
        .spoke_samples (spoke_samples_reg),
        .req           (adm_req),
        .rsp           (adm_rsp)
    );

    // Decoder and run sequencer
    rse_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_ch.valid),
        .in_ready    (in_ch.ready),
        .data_byte   (in_ch.data_byte),
        .in_tail     (in_ch.in_tail),
        .spoke_start (in_ch.spoke_start),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .result      (result),
        .adm_req     (adm_req),
        .adm_rsp     (adm_rsp)
    );

    // Output fields
    assign out_ch.sample_0   = result.sample[0];
    assign out_ch.sample_1   = result.sample[1];
    assign out_ch.sample_2   = result.sample[2];
    assign out_ch.sample_3   = result.sample[3];
    assign out_ch.sample_4   = result.sample[4];
    assign out_ch.sample_5   = result.sample[5];
    assign out_ch.sample_6   = result.sample[6];
    assign out_ch.sample_7   = result.sample[7];
    assign out_ch.pair_count = result.pair_count;
    assign out_ch.run_last   = result.run_last;
    assign out_ch.truncated  = result.truncated;

endmodule

FILE: hw/rtl/rse_admit.sv
// Shared admit unit: fits requested pairs under the per-spoke sample limit.
module rse_admit
    import rse_pkg::*;
(
    input  logic [CNT_W-1:0] spoke_samples,
    input  adm_req_t         req,
    output adm_rsp_t         rsp
);

    logic [CNT_W-1:0]  limit;
    logic [CNT_W-1:0]  gap;
    logic [ROOM_W-1:0] room;
    logic [PAIR_W-1:0] got;

    // Limit clamp, then room in whole pairs
    always_comb
    begin
        limit = (spoke_samples > MAX_SPOKE_SAMPLES) ? MAX_SPOKE_SAMPLES : spoke_samples;
        gap   = (limit > req.emitted) ? (limit - req.emitted) : '0;
        room  = gap[CNT_W-1:1];
        got   = (room < ROOM_W'(req.want)) ? room[PAIR_W-1:0] : req.want;
    end

    assign rsp.got          = got;
    assign rsp.dropped      = (got < req.want);
    assign rsp.emitted_next = req.emitted + {(CNT_W-PAIR_W-1)'(0), got, 1'b0};

endmodule

FILE: hw/rtl/rse_seq.sv
// Byte decoder and run sequencer, with the output result register.
`include "assert_macros.svh"

module rse_seq
    import rse_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              in_tail,
    input  logic              spoke_start,
    output logic              out_valid,
    input  logic              out_ready,
    output result_t           result,
    output adm_req_t          adm_req,
    input  adm_rsp_t          adm_rsp
);

    seq_state_t        state_reg, state_next;
    esc_phase_t        phase_reg, phase_next, phase_base;
    logic [BYTE_W-1:0] run_len_reg, run_len_next;
    logic [BYTE_W-1:0] remain_reg, remain_next;
    logic [BYTE_W-1:0] s0_reg, s0_next, s1_reg, s1_next;
    logic [CNT_W-1:0]  emitted_reg, emitted_next, emitted_base;
    logic              out_valid_reg, out_valid_next;
    result_t           result_reg, result_next;

    logic              slot_free;
    logic              accept;
    logic              emit;
    logic              emit_last;
    logic [PAIR_W-1:0] want;
    logic [BYTE_W-1:0] emit_s0, emit_s1;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) && slot_free;
    assign accept    = in_valid && in_ready;

    // Decode and sequencing
    always_comb
    begin
        state_next   = state_reg;
        run_len_next = run_len_reg;
        remain_next  = remain_reg;
        s0_next      = s0_reg;
        s1_next      = s1_reg;
        emit         = 1'b0;
        emit_last    = 1'b1;
        want         = '0;
        emit_s0      = s0_reg;
        emit_s1      = s1_reg;

        emitted_base = (accept && spoke_start) ? '0 : emitted_reg;
        phase_base   = (accept && spoke_start) ? PH_NORMAL : phase_reg;
        phase_next   = phase_base;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (in_tail)
                    begin
                        phase_next = PH_NORMAL;
                        emit       = 1'b1;
                        want       = 3'd1;
                        emit_s0    = {data_byte[3:0], 4'h0};
                        emit_s1    = data_byte & NIB_HI;
                    end
                    else if (phase_base == PH_COUNT)
                    begin
                        run_len_next = data_byte;
                        phase_next   = PH_VALUE;
                    end
                    else if (phase_base == PH_VALUE)
                    begin
                        phase_next = PH_NORMAL;
                        s0_next    = {data_byte[3:0], 4'h0} | NIB_LO;
                        s1_next    = (data_byte & NIB_HI) | NIB_LO;
                        if (run_len_reg != '0)
                        begin
                            remain_next = run_len_reg;
                            state_next  = ST_RUN;
                        end
                    end
                    else if (data_byte == ESC_BYTE)
                    begin
                        phase_next = PH_COUNT;
                    end
                    else
                    begin
                        phase_next = PH_NORMAL;
                        emit       = 1'b1;
                        want       = 3'd1;
                        emit_s0    = {data_byte[3:0], 4'h0} | NIB_LO;
                        emit_s1    = (data_byte & NIB_HI) | NIB_LO;
                    end
                end
            end
            ST_RUN:
            begin
                if (slot_free)
                begin
                    emit      = 1'b1;
                    want      = (remain_reg >= BYTE_W'(PAIRS_PER_RESULT)) ?
                                PAIRS_PER_RESULT : remain_reg[PAIR_W-1:0];
                    emit_last = (remain_reg <= BYTE_W'(PAIRS_PER_RESULT));
                    remain_next = remain_reg - BYTE_W'(want);
                    if (emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        emitted_next = emit ? adm_rsp.emitted_next : emitted_base;
    end

    assign adm_req.want    = want;
    assign adm_req.emitted = emitted_base;

    // Result assembly
    always_comb
    begin
        result_next = result_reg;
        if (emit)
        begin
            for (int i = 0; i < OUT_PAIRS; i++)
            begin
                result_next.sample[2*i]   = (PAIR_W'(i) < adm_rsp.got) ? emit_s0 : '0;
                result_next.sample[2*i+1] = (PAIR_W'(i) < adm_rsp.got) ? emit_s1 : '0;
            end
            result_next.pair_count = adm_rsp.got;
            result_next.run_last   = emit_last;
            result_next.truncated  = adm_rsp.dropped;
        end
        out_valid_next = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_NORMAL;
            run_len_reg   <= '0;
            remain_reg    <= '0;
            emitted_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            run_len_reg   <= run_len_next;
            remain_reg    <= remain_next;
            emitted_reg   <= emitted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        s0_reg     <= s0_next;
        s1_reg     <= s1_next;
        result_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    // Checks
    `RSE_ASSERT(a_emitted_cap, emitted_reg <= MAX_SPOKE_SAMPLES, "sample count past maximum")
    `RSE_ASSERT(a_run_nonzero, (state_reg == ST_RUN) |-> (remain_reg != '0),
                "run state with nothing left")
    `RSE_ASSERT(a_pairs_range, out_valid_reg |-> (result_reg.pair_count <= PAIRS_PER_RESULT),
                "too many pairs in result")
    `RSE_ASSERT(a_trunc_pairs,
                (out_valid_reg && !result_reg.truncated && result_reg.run_last &&
                 $past(state_reg) == ST_IDLE && $past(emit)) |-> (result_reg.pair_count == 3'd1),
                "single-byte result lost its pair without a flag")

endmodule
